### rtl/core/cds_pkg.sv
// Shared types and constants of the cohort distribution statistics unit.
// No dependencies; every other file of the block but cds_divider refers to this package.
`default_nettype none
package cds_pkg;

   localparam int FRAC_W = 17;
   localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
   localparam int TOTAL_W = 48;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;
   localparam int COUNT_W = 11;
   localparam int VAR_W = 33;
   localparam int PCT_DIV = 100;
   localparam int PCT_LO = 5;
   localparam int PCT_HI = 95;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_MEAN,
      ST_CORR,
      ST_DRAIN,
      ST_FLUSH,
      ST_VAR,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic              insert;
      logic              drain;
      logic [FRAC_W-1:0] value;
   } cell_ctl_type;

endpackage
`default_nettype wire

### rtl/core/cds_req_if.sv
// Input channel of the cohort statistics unit: one cell result per transfer.
// Depends on cds_pkg for the field widths.
`default_nettype none
interface cds_req_if;
   logic                        valid;
   logic                        ready;
   logic                        cohort;
   logic [cds_pkg::FRAC_W-1:0]  fraction;
   logic                        detected;
   logic [31:0]                 events;
   logic [31:0]                 draws;

   modport source(output valid, cohort, fraction, detected, events, draws, input ready);
   modport sink(input valid, cohort, fraction, detected, events, draws, output ready);
endinterface
`default_nettype wire

### rtl/core/cds_rsp_if.sv
// Result channel of the cohort statistics unit: one summary per transfer.
// Depends on cds_pkg for the field widths.
`default_nettype none
interface cds_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         cohort_tag;
   logic [cds_pkg::COUNT_W-1:0]  cell_count;
   logic [cds_pkg::FRAC_W-1:0]   mean;
   logic [cds_pkg::VAR_W-1:0]    variance;
   logic [cds_pkg::FRAC_W-1:0]   minimum;
   logic [cds_pkg::FRAC_W-1:0]   low_quantile;
   logic [cds_pkg::FRAC_W-1:0]   median;
   logic [cds_pkg::FRAC_W-1:0]   high_quantile;
   logic [cds_pkg::FRAC_W-1:0]   maximum;
   logic [cds_pkg::COUNT_W-1:0]  detected_count;
   logic [cds_pkg::TOTAL_W-1:0]  event_total;
   logic [cds_pkg::TOTAL_W-1:0]  draw_total;

   modport source(output valid, cohort_tag, cell_count, mean, variance, minimum,
                  low_quantile, median, high_quantile, maximum, detected_count,
                  event_total, draw_total, input ready);
   modport sink(input valid, cohort_tag, cell_count, mean, variance, minimum,
                low_quantile, median, high_quantile, maximum, detected_count,
                event_total, draw_total, output ready);
endinterface
`default_nettype wire

### rtl/core/cds_cell.sv
// One cell of the sorting row: holds one fraction, inserts in order, drains to the left.
// Depends on cds_pkg for the broadcast control struct.
`default_nettype none
module cds_cell (
   input  wire logic                        clock,
   input  wire cds_pkg::cell_ctl_type       ctl,
   input  wire logic                        occupied,
   input  wire logic                        left_gt,
   input  wire logic [cds_pkg::FRAC_W-1:0]  left_val,
   input  wire logic [cds_pkg::FRAC_W-1:0]  right_val,
   output logic                             gt,
   output logic [cds_pkg::FRAC_W-1:0]       value
);
   logic [cds_pkg::FRAC_W-1:0] value_ff;
   logic [cds_pkg::FRAC_W-1:0] value_in;

   assign gt    = !occupied || (value_ff > ctl.value);
   assign value = value_ff;

   always_comb begin
      if (ctl.drain) begin
         value_in = right_val;
      end else if (ctl.insert && gt) begin
         value_in = left_gt ? left_val : ctl.value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end
endmodule
`default_nettype wire

### rtl/core/cds_divider.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions of the unit.
// No package dependencies.
`default_nettype none
module cds_divider #(
   parameter int DW = 45,
   parameter int VW = 11
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic               done,
   output logic [DW-1:0]      quotient,
   output logic [VW-1:0]      remainder
);
   localparam int CNTW = $clog2(DW);

   logic [DW-1:0]   quo_ff;
   logic [VW-1:0]   rem_ff;
   logic [VW-1:0]   dvs_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff;
   logic            done_ff;
   logic [VW:0]     trial;
   logic [VW:0]     diff;
   logic            fits;

   assign trial = {rem_ff, quo_ff[DW-1]};
   assign fits  = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DW-2:0], fits};
         rem_ff <= fits ? diff[VW-1:0] : trial[VW-1:0];
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNTW'(DW - 1));
         if (busy_ff && (cnt_ff == CNTW'(DW - 1))) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

### rtl/core/cohort_distribution_stats_unit.sv
// Top level of the cohort distribution statistics unit: sorting cell row,
// accumulators, shared divider and sequencer. Depends on cds_pkg, cds_req_if,
// cds_rsp_if, cds_cell and cds_divider.
//
//   Channel   Direction  Contents
//   req_chan  in         cohort, fraction, detected, events, draws
//   rsp_chan  out        summary of one cohort
//   csr_*     in         cohort_size write
//
// Cell results are taken one per cycle while in the load step; each one is inserted
// in sorted order into the cell row in the same cycle. After the last cell of a
// cohort, the mean and correction divisions, a drain through the row, a flush of
// the deviation pipeline, the variance division and a send step run before input
// is taken again. Divider width DW = 34 + clog2(MAX_CELLS + 1) (45 at the default).
// The summary waits in an output register; the send step stalls only while it is full.
// Reset is synchronous and active high; the result stalls as long as needed.
`default_nettype none
module cohort_distribution_stats_unit #(
   parameter int MAX_CELLS = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   cds_req_if.sink                            req_chan,
   cds_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_wr_en,
   input  wire logic [cds_pkg::COUNT_W-1:0]   csr_wr_data
);
   localparam int CW = $clog2(MAX_CELLS + 1);
   localparam int VW = (CW > 7) ? CW : 7;
   localparam int DW = 34 + CW;
   localparam int SW = cds_pkg::FRAC_W + CW;
   localparam int FW = cds_pkg::FRAC_W;
   localparam int TW = cds_pkg::TOTAL_W;
   localparam int PW = CW + 7;
   localparam int KS = CW + 14;
   localparam longint KM = ((longint'(1) << KS) + longint'(cds_pkg::PCT_DIV) - 1)
                           / longint'(cds_pkg::PCT_DIV);
   localparam int PRW = PW + KS - 6;

   cds_pkg::state_type state_ff, state_in;
   logic                       issue_ff;
   logic [cds_pkg::COUNT_W-1:0] size_ff;
   logic [CW-1:0]              n_eff;
   logic [CW-1:0]              seen_ff, seen_next, last;
   logic [SW-1:0]              sum_ff;
   logic [CW-1:0]              det_ff;
   logic [TW-1:0]              ev_ff, dr_ff;
   logic [TW:0]                ev_add, dr_add;
   logic                       tag_ff;
   logic                       accept, complete, rsp_done;
   logic [FW-1:0]              frac_sat;

   logic                       div_start, div_done;
   logic [DW-1:0]              div_dividend, div_quo;
   logic [VW-1:0]              div_divisor, div_rem;
   logic [DW-1:0]              acc_w, corr_w;
   logic [2*CW-1:0]            rr;

   logic [PW-1:0]              lo_scale_ff, hi_scale_ff;
   logic [PRW-1:0]             lo_prod_ff, hi_prod_ff;
   logic [CW-1:0]              klo, khi;

   logic [FW-1:0]              q_ff;
   logic [CW-1:0]              r_ff, corr_ff, idx_ff;
   logic [cds_pkg::VAR_W-1:0]  var_ff;
   logic [FW-1:0]              min_ff, lo_ff, med_ff, hi_ff, max_ff;
   logic [FW-1:0]              x, dx_ff;
   logic                       dv1_ff, dv2_ff;
   logic [2*FW-1:0]            prod_ff;
   logic [DW-1:0]              acc_ff;

   logic                        load_out;
   logic                        out_valid_ff;
   logic                        out_tag_ff;
   logic [cds_pkg::COUNT_W-1:0] out_count_ff, out_det_ff;
   logic [FW-1:0]               out_mean_ff, out_min_ff, out_lo_ff;
   logic [FW-1:0]               out_med_ff, out_hi_ff, out_max_ff;
   logic [cds_pkg::VAR_W-1:0]   out_var_ff;
   logic [TW-1:0]               out_ev_ff, out_dr_ff;

   cds_pkg::cell_ctl_type      ctl;
   logic [FW-1:0]              cell_val [MAX_CELLS];
   logic                       cell_gt [MAX_CELLS];

   always_comb begin
      if (size_ff < 11'd2) begin
         n_eff = CW'(2);
      end else if (32'(size_ff) > 32'(MAX_CELLS)) begin
         n_eff = CW'(MAX_CELLS);
      end else begin
         n_eff = CW'(size_ff);
      end
   end

   assign accept    = req_chan.valid && req_chan.ready;
   assign rsp_done  = rsp_chan.valid && rsp_chan.ready;
   assign load_out  = (state_ff == cds_pkg::ST_SEND) && (!out_valid_ff || rsp_chan.ready);
   assign seen_next = seen_ff + 1'b1;
   assign complete  = seen_next >= n_eff;
   assign last      = seen_ff - 1'b1;
   assign frac_sat  = (req_chan.fraction > cds_pkg::FRAC_ONE) ? cds_pkg::FRAC_ONE
                                                             : req_chan.fraction;
   assign ev_add    = {1'b0, ev_ff} + (TW + 1)'(req_chan.events);
   assign dr_add    = {1'b0, dr_ff} + (TW + 1)'(req_chan.draws);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= 11'd1024;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || load_out) begin
         seen_ff <= '0;
         sum_ff  <= '0;
         det_ff  <= '0;
         ev_ff   <= '0;
         dr_ff   <= '0;
      end else if (accept) begin
         seen_ff <= seen_next;
         sum_ff  <= sum_ff + SW'(frac_sat);
         det_ff  <= det_ff + CW'(req_chan.detected);
         ev_ff   <= ev_add[TW] ? cds_pkg::TOTAL_MAX : ev_add[TW-1:0];
         dr_ff   <= dr_add[TW] ? cds_pkg::TOTAL_MAX : dr_add[TW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tag_ff <= req_chan.cohort;
      end
   end

   // Sorting row of cells.
   assign ctl.insert = accept;
   assign ctl.drain  = (state_ff == cds_pkg::ST_DRAIN);
   assign ctl.value  = frac_sat;

   for (genvar i = 0; i < MAX_CELLS; i++) begin : g_cell
      logic          l_gt;
      logic [FW-1:0] l_val, r_val;
      if (i == 0) begin : g_first
         assign l_gt  = 1'b0;
         assign l_val = '0;
      end else begin : g_mid
         assign l_gt  = cell_gt[i-1];
         assign l_val = cell_val[i-1];
      end
      if (i == MAX_CELLS - 1) begin : g_last
         assign r_val = '0;
      end else begin : g_inner
         assign r_val = cell_val[i+1];
      end
      cds_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .occupied  (CW'(i) < seen_ff),
         .left_gt   (l_gt),
         .left_val  (l_val),
         .right_val (r_val),
         .gt        (cell_gt[i]),
         .value     (cell_val[i])
      );
   end

   // Quantile indices by reciprocal multiplication; settled long before the drain.
   always_ff @(posedge clock) begin
      lo_scale_ff <= PW'(last) * PW'(cds_pkg::PCT_LO);
      hi_scale_ff <= PW'(last) * PW'(cds_pkg::PCT_HI);
      lo_prod_ff  <= PRW'(lo_scale_ff) * PRW'(KM);
      hi_prod_ff  <= PRW'(hi_scale_ff) * PRW'(KM);
   end

   assign klo = CW'(lo_prod_ff >> KS);
   assign khi = CW'(hi_prod_ff >> KS);

   // Divider operands.
   assign rr     = r_ff * r_ff;
   assign acc_w  = acc_ff;
   assign corr_w = DW'(corr_ff);

   cds_divider #(.DW(DW), .VW(VW)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cds_pkg::ST_LOAD;
         issue_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         issue_ff <= (state_in != state_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      div_start    = 1'b0;
      div_dividend = DW'(sum_ff);
      div_divisor  = VW'(seen_ff);
      req_chan.ready = 1'b0;
      case (state_ff)
         cds_pkg::ST_LOAD: begin
            req_chan.ready = 1'b1;
            if (accept && complete) begin
               state_in = cds_pkg::ST_MEAN;
            end
         end
         cds_pkg::ST_MEAN: begin
            div_start = issue_ff;
            if (div_done) begin
               state_in = cds_pkg::ST_CORR;
            end
         end
         cds_pkg::ST_CORR: begin
            div_start    = issue_ff;
            div_dividend = DW'(rr) + DW'(last);
            if (div_done) begin
               state_in = cds_pkg::ST_DRAIN;
            end
         end
         cds_pkg::ST_DRAIN: begin
            if (idx_ff == last) begin
               state_in = cds_pkg::ST_FLUSH;
            end
         end
         cds_pkg::ST_FLUSH: begin
            if (!dv1_ff && !dv2_ff) begin
               state_in = cds_pkg::ST_VAR;
            end
         end
         cds_pkg::ST_VAR: begin
            div_start    = issue_ff;
            div_dividend = (acc_w >= corr_w) ? (acc_w - corr_w) : '0;
            if (div_done) begin
               state_in = cds_pkg::ST_SEND;
            end
         end
         cds_pkg::ST_SEND: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               state_in = cds_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = cds_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (div_done) begin
         case (state_ff)
            cds_pkg::ST_MEAN: begin
               q_ff <= FW'(div_quo);
               r_ff <= CW'(div_rem);
            end
            cds_pkg::ST_CORR: corr_ff <= CW'(div_quo);
            cds_pkg::ST_VAR:  var_ff  <= cds_pkg::VAR_W'(div_quo);
            default: begin
            end
         endcase
      end
   end

   // Drain pass: order statistics and squared deviations from the floor mean.
   assign x = cell_val[0];

   always_ff @(posedge clock) begin
      if (state_ff == cds_pkg::ST_CORR) begin
         idx_ff <= '0;
         acc_ff <= '0;
      end else begin
         if (state_ff == cds_pkg::ST_DRAIN) begin
            idx_ff <= idx_ff + 1'b1;
            if (idx_ff == '0) min_ff <= x;
            if (idx_ff == klo) lo_ff <= x;
            if (idx_ff == (last >> 1)) med_ff <= x;
            if (idx_ff == khi) hi_ff <= x;
            if (idx_ff == last) max_ff <= x;
         end
         if (dv2_ff) begin
            acc_ff <= acc_ff + DW'(prod_ff);
         end
      end
      dx_ff   <= (x >= q_ff) ? (x - q_ff) : (q_ff - x);
      prod_ff <= dx_ff * dx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv1_ff <= 1'b0;
         dv2_ff <= 1'b0;
      end else begin
         dv1_ff <= (state_ff == cds_pkg::ST_DRAIN);
         dv2_ff <= dv1_ff;
      end
   end

   // Output register of the summary.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_done) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_tag_ff   <= tag_ff;
         out_count_ff <= cds_pkg::COUNT_W'(seen_ff);
         out_mean_ff  <= q_ff;
         out_var_ff   <= var_ff;
         out_min_ff   <= min_ff;
         out_lo_ff    <= lo_ff;
         out_med_ff   <= med_ff;
         out_hi_ff    <= hi_ff;
         out_max_ff   <= max_ff;
         out_det_ff   <= cds_pkg::COUNT_W'(det_ff);
         out_ev_ff    <= ev_ff;
         out_dr_ff    <= dr_ff;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.cohort_tag     = out_tag_ff;
   assign rsp_chan.cell_count     = out_count_ff;
   assign rsp_chan.mean           = out_mean_ff;
   assign rsp_chan.variance       = out_var_ff;
   assign rsp_chan.minimum        = out_min_ff;
   assign rsp_chan.low_quantile   = out_lo_ff;
   assign rsp_chan.median         = out_med_ff;
   assign rsp_chan.high_quantile  = out_hi_ff;
   assign rsp_chan.maximum        = out_max_ff;
   assign rsp_chan.detected_count = out_det_ff;
   assign rsp_chan.event_total    = out_ev_ff;
   assign rsp_chan.draw_total     = out_dr_ff;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=>
         (rsp_chan.valid && $stable(rsp_chan.variance) && $stable(rsp_chan.cell_count)))
      else $error("pending summary changed before its transfer");

   a_flushed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cds_pkg::ST_VAR) |-> (!dv1_ff && !dv2_ff))
      else $error("variance division started before the drain pipeline emptied");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      32'(seen_ff) <= 32'(MAX_CELLS))
      else $error("cell count beyond the row length");

   a_send_after_var: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(state_ff) == cds_pkg::ST_SEND)
      else $error("summary offered outside the send step");
endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench of the cohort distribution statistics unit.
// Depends on cds_pkg, cds_req_if, cds_rsp_if and cohort_distribution_stats_unit.
// Cohort summaries are predicted in the bench from the cell results sent and each is checked field by field.
`timescale 1ns / 1ps
module testbench;

   localparam int CELL_LIMIT = 1024;
   localparam int SETTLE_CYCLES = 1500;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic                         cohort;
      logic [cds_pkg::FRAC_W-1:0]   fraction;
      logic                         detected;
      logic [31:0]                  events;
      logic [31:0]                  draws;
   } cell_type;

   typedef struct packed {
      logic                         resize;
      logic [cds_pkg::COUNT_W-1:0]  size;
      cell_type                     item;
   } step_type;

   typedef struct packed {
      logic                         cohort_tag;
      logic [cds_pkg::COUNT_W-1:0]  cell_count;
      logic [cds_pkg::FRAC_W-1:0]   mean;
      logic [cds_pkg::VAR_W-1:0]    variance;
      logic [cds_pkg::FRAC_W-1:0]   minimum;
      logic [cds_pkg::FRAC_W-1:0]   low_quantile;
      logic [cds_pkg::FRAC_W-1:0]   median;
      logic [cds_pkg::FRAC_W-1:0]   high_quantile;
      logic [cds_pkg::FRAC_W-1:0]   maximum;
      logic [cds_pkg::COUNT_W-1:0]  detected_count;
      logic [cds_pkg::TOTAL_W-1:0]  event_total;
      logic [cds_pkg::TOTAL_W-1:0]  draw_total;
   } summary_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [cds_pkg::COUNT_W-1:0] csr_wr_data = '0;

   cds_req_if req_chan();
   cds_rsp_if rsp_chan();

   cohort_distribution_stats_unit dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bench copy of the block state.
   longint unsigned fraction_cells[CELL_LIMIT];
   logic [cds_pkg::COUNT_W-1:0] cohort_setting = 11'd1024;
   int unsigned cells_held = 0;
   longint unsigned fraction_total = 0;
   int unsigned detected_held = 0;
   longint unsigned event_acc = 0;
   longint unsigned draw_acc = 0;

   summary_type pending_summaries[$];
   int failures = 0;
   int cells_sent = 0;
   int summaries_seen = 0;
   bit quiet = 1'b0;
   int hold_request = 0;
   int last_fraction = 0;

   function automatic longint unsigned add_saturated(longint unsigned acc, longint unsigned x);
      longint unsigned s;
      s = acc + x;
      return (s > 64'(cds_pkg::TOTAL_MAX)) ? 64'(cds_pkg::TOTAL_MAX) : s;
   endfunction

   function automatic void predict_cohort(cell_type c);
      int unsigned n_eff;
      int unsigned count;
      longint unsigned frac;
      longint unsigned q;
      longint unsigned r;
      longint unsigned acc;
      longint unsigned d;
      longint unsigned corr;
      longint unsigned sorted[];
      int unsigned last;
      summary_type s;
      frac = (c.fraction > cds_pkg::FRAC_ONE) ? 64'(cds_pkg::FRAC_ONE) : 64'(c.fraction);
      n_eff = 32'(cohort_setting);
      if (n_eff < 2) n_eff = 2;
      if (n_eff > CELL_LIMIT) n_eff = CELL_LIMIT;
      if (cells_held < CELL_LIMIT) fraction_cells[cells_held] = frac;
      cells_held++;
      fraction_total += frac;
      detected_held += 32'(c.detected);
      event_acc = add_saturated(event_acc, 64'(c.events));
      draw_acc = add_saturated(draw_acc, 64'(c.draws));
      if (cells_held < n_eff) return;
      count = cells_held;
      q = fraction_total / count;
      r = fraction_total % count;
      acc = 0;
      sorted = new[count];
      for (int i = 0; i < count; i++) begin
         d = (fraction_cells[i] >= q) ? fraction_cells[i] - q : q - fraction_cells[i];
         acc += d * d;
         sorted[i] = fraction_cells[i];
      end
      corr = (r * r + count - 1) / count;
      acc = (acc >= corr) ? acc - corr : 0;
      sorted.sort();
      last = count - 1;
      s.cohort_tag = c.cohort;
      s.cell_count = count[cds_pkg::COUNT_W-1:0];
      s.mean = q[cds_pkg::FRAC_W-1:0];
      s.variance = cds_pkg::VAR_W'(acc / count);
      s.minimum = cds_pkg::FRAC_W'(sorted[0]);
      s.low_quantile = cds_pkg::FRAC_W'(sorted[(last * 5) / 100]);
      s.median = cds_pkg::FRAC_W'(sorted[last / 2]);
      s.high_quantile = cds_pkg::FRAC_W'(sorted[(last * 95) / 100]);
      s.maximum = cds_pkg::FRAC_W'(sorted[last]);
      s.detected_count = detected_held[cds_pkg::COUNT_W-1:0];
      s.event_total = event_acc[cds_pkg::TOTAL_W-1:0];
      s.draw_total = draw_acc[cds_pkg::TOTAL_W-1:0];
      pending_summaries = {pending_summaries, s};
      cells_held = 0;
      fraction_total = 0;
      detected_held = 0;
      event_acc = 0;
      draw_acc = 0;
   endfunction

   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (quiet || roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_cell(cell_type c);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.cohort = c.cohort;
      req_chan.fraction = c.fraction;
      req_chan.detected = c.detected;
      req_chan.events = c.events;
      req_chan.draws = c.draws;
      do @(posedge clock); while (!req_chan.ready);
      predict_cohort(c);
      cells_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_summaries.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_cohort_size(logic [cds_pkg::COUNT_W-1:0] size);
      wait_idle();
      csr_wr_en = 1'b1;
      csr_wr_data = size;
      @(negedge clock);
      csr_wr_en = 1'b0;
      cohort_setting = size;
   endtask

   function automatic cell_type random_cell();
      cell_type c;
      case ($urandom_range(9))
         0: c.fraction = '0;
         1: c.fraction = cds_pkg::FRAC_ONE;
         2: c.fraction = cds_pkg::FRAC_W'($urandom_range(65537, 131071));
         3: c.fraction = cds_pkg::FRAC_W'(last_fraction);
         4: c.fraction = cds_pkg::FRAC_W'($urandom_range(0, 255));
         default: c.fraction = cds_pkg::FRAC_W'($urandom_range(0, 65536));
      endcase
      last_fraction = int'(c.fraction);
      c.cohort = 1'($urandom_range(1));
      c.detected = 1'($urandom_range(1));
      c.events = $urandom;
      c.draws = $urandom;
      return c;
   endfunction

   // Result side: random back-pressure plus one long hold on request.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_chan.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready = 1'b1;
            if (!quiet && $urandom_range(3) == 0)
               stall_left = ($urandom_range(9) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 3);
         end
      end
   end

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      summary_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         summaries_seen++;
         if (pending_summaries.size() == 0) begin
            $display("%0t: unexpected summary transfer, actual count %0d", $time,
                     rsp_chan.cell_count);
            failures++;
         end else begin
            want = pending_summaries.pop_front();
            check_field("cohort_tag", want.cohort_tag, rsp_chan.cohort_tag);
            check_field("cell_count", want.cell_count, rsp_chan.cell_count);
            check_field("mean", want.mean, rsp_chan.mean);
            check_field("variance", want.variance, rsp_chan.variance);
            check_field("minimum", want.minimum, rsp_chan.minimum);
            check_field("low_quantile", want.low_quantile, rsp_chan.low_quantile);
            check_field("median", want.median, rsp_chan.median);
            check_field("high_quantile", want.high_quantile, rsp_chan.high_quantile);
            check_field("maximum", want.maximum, rsp_chan.maximum);
            check_field("detected_count", want.detected_count, rsp_chan.detected_count);
            check_field("event_total", want.event_total, rsp_chan.event_total);
            check_field("draw_total", want.draw_total, rsp_chan.draw_total);
         end
      end
   end

   always @(posedge clock) begin
      int idle_cycles;
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   step_type directed[16];

   initial begin
      req_chan.valid = 1'b0;
      req_chan.cohort = 1'b0;
      req_chan.fraction = '0;
      req_chan.detected = 1'b0;
      req_chan.events = '0;
      req_chan.draws = '0;
      // Sizes 0 and 1 act as 2; a drop from 10 to 4 after six cells closes a cohort of seven.
      directed = '{
         '{1'b1, 11'd0,  '{1'b0, 17'h00000, 1'b0, 32'h0, 32'h0}},
         '{1'b0, 11'd0,  '{1'b1, 17'h1FFFF, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF}},
         '{1'b1, 11'd1,  '{1'b0, 17'h10000, 1'b1, 32'hFFFFFFFF, 32'h0}},
         '{1'b0, 11'd1,  '{1'b0, 17'h10000, 1'b0, 32'h0, 32'hFFFFFFFF}},
         '{1'b0, 11'd1,  '{1'b1, 17'h10001, 1'b1, 32'h1, 32'h1}},
         '{1'b0, 11'd1,  '{1'b0, 17'h00000, 1'b1, 32'h80000000, 32'h7FFFFFFF}},
         '{1'b1, 11'd3,  '{1'b0, 17'h00001, 1'b0, 32'h5, 32'h9}},
         '{1'b0, 11'd3,  '{1'b1, 17'h00002, 1'b1, 32'h5, 32'h9}},
         '{1'b0, 11'd3,  '{1'b1, 17'h0FFFF, 1'b0, 32'h5, 32'h9}},
         '{1'b1, 11'd10, '{1'b0, 17'h00010, 1'b1, 32'h10, 32'h20}},
         '{1'b0, 11'd10, '{1'b0, 17'h08000, 1'b0, 32'h10, 32'h20}},
         '{1'b0, 11'd10, '{1'b1, 17'h0C000, 1'b1, 32'h10, 32'h20}},
         '{1'b0, 11'd10, '{1'b0, 17'h04000, 1'b0, 32'h10, 32'h20}},
         '{1'b0, 11'd10, '{1'b1, 17'h10000, 1'b1, 32'h10, 32'h20}},
         '{1'b0, 11'd10, '{1'b0, 17'h00000, 1'b0, 32'h10, 32'h20}},
         '{1'b1, 11'd4,  '{1'b1, 17'h12345, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF}}
      };
      repeat (9) @(negedge clock);
      reset = 1'b0;
      foreach (directed[i]) begin
         if (directed[i].resize) write_cohort_size(directed[i].size);
         send_cell(directed[i].item);
      end
      // Small cohorts while the result side holds off, so the input stalls.
      write_cohort_size(11'd4);
      hold_request = 600;
      repeat (40) send_cell(random_cell());
      for (int phase = 0; phase < 12; phase++) begin
         write_cohort_size(cds_pkg::COUNT_W'($urandom_range(2, 20)));
         quiet = (phase % 4 == 3);
         repeat (45) send_cell(random_cell());
      end
      quiet = 1'b0;
      write_cohort_size(11'd2047);
      repeat (1024) send_cell(random_cell());
      write_cohort_size(11'd1024);
      repeat (50) send_cell(random_cell());
      write_cohort_size(11'd2);
      repeat (30) send_cell(random_cell());
      wait_idle();
      $display("Sent %0d cell results and checked %0d cohort summaries,", cells_sent,
               summaries_seen);
      $display("cohort sizes from 2 up to 1024, with a mid-cohort size drop.");
      if (failures == 0 && pending_summaries.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### cohort_distribution_stats_unit.f
rtl/core/cds_pkg.sv
rtl/core/cds_req_if.sv
rtl/core/cds_rsp_if.sv
rtl/core/cds_cell.sv
rtl/core/cds_divider.sv
rtl/core/cohort_distribution_stats_unit.sv
verif/testbench.sv
